// ----- hdl/npt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npt_pkg
// Types and constants of the network prefix table unit.
// ---------------------------------------------------------------------------
package npt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ID_BITS       = 16;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

   localparam int REQ_BITS      = 88;
   localparam int RSP_BITS      = 88;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_FIND  = 2'd1;
   localparam logic [1:0] CMD_MATCH = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_MATCHED   = 3'd5;
   localparam logic [2:0] ST_NO_MATCH  = 3'd6;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic [31:0]        prefix;
      logic [31:0]        netmask;
      logic [ID_BITS-1:0] ident;
   } entry_type;

endpackage

// ----- hdl/network_prefix_table_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// network_prefix_table_unit
// Table of IPv4 network entries with add, find-by-id and interface match.
// ---------------------------------------------------------------------------
// Usage:
//   A command enters on the req_ stream (add, find by id, match interface);
//   each command gives exactly one transfer on the rsp_ stream with status,
//   id, prefix and mask of the entry concerned. first_id is written on the
//   csr_ port while the unit is idle, a rule on the user that the block does not enforce.
//   The entries sit in one synchronous RAM. A command scans it in insertion
//   order, one read issued per cycle, compare in the cycle after the read.
//   A scan stops at the first entry that hits; a command that needs no
//   scan, or one on an empty table, reads no entry; one command at a time.
//   An add writes the new entry in the last scan cycle.
//   Reset empties the table and loads the next id with 1. The result sits
//   in an output register; a new command is taken while it waits, and a
//   stalled receiver holds the unit after its scan until rsp_tready.
// ---------------------------------------------------------------------------
module network_prefix_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   // command[1:0], address[33:2], mask[65:34], lookup_id[81:66]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [npt_pkg::REQ_BITS-1:0] req_tdata,
   // status[2:0], net_id[18:3], entry_address[50:19], entry_mask[82:51]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [npt_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic                         csr_we,
   input  logic [15:0]                  csr_wdata
);

   npt_pkg::fsm_type                state_ff, state_in;
   logic [1:0]                      cmd_ff, cmd_in;
   logic [31:0]                     addr_ff, addr_in;
   logic [31:0]                     mask_ff, mask_in;
   logic [15:0]                     lid_ff, lid_in;
   logic [31:0]                     lo_ff, lo_in;
   logic [npt_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic [npt_pkg::CNT_BITS-1:0]    issue_ff, issue_in;
   logic                            pend_ff, pend_in;
   logic [15:0]                     first_id_ff, first_id_in;
   logic [npt_pkg::ID_BITS-1:0]     next_id_ff, next_id_in;
   logic [2:0]                      res_status_ff, res_status_in;
   logic [15:0]                     res_id_ff, res_id_in;
   logic [31:0]                     res_addr_ff, res_addr_in;
   logic [31:0]                     res_mask_ff, res_mask_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [npt_pkg::RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;

   npt_pkg::entry_type              mem [npt_pkg::TABLE_ENTRIES];
   npt_pkg::entry_type              rd_data_ff;
   npt_pkg::entry_type              mem_wdata;
   logic                            mem_we;
   logic [npt_pkg::IDX_BITS-1:0]    mem_waddr;
   logic [npt_pkg::IDX_BITS-1:0]    rd_addr;

   logic [31:0]                     cm;
   logic                            incl;
   logic                            hit;
   logic                            skip;
   logic                            done;
   logic                            found;

   function automatic logic [31:0] class_mask(input logic [31:0] p);
      logic [31:0] m;
      if (p[31] == 1'b0) begin
         m = 32'hFF00_0000;
      end else if (p[31:30] == 2'b10) begin
         m = 32'hFFFF_0000;
      end else if (p[31:29] == 3'b110) begin
         m = 32'hFFFF_FF00;
      end else begin
         m = 32'h0;
      end
      return m;
   endfunction

   // lo_ff: bits below the lowest set bit of the interface mask (all ones
   // for a zero mask); an entry mask is no longer than the interface mask
   // exactly when it has no bit there.
   always_comb begin
      cm = class_mask(rd_data_ff.prefix);
      if (rd_data_ff.prefix == 32'h0) begin
         incl = 1'b1;
      end else if (rd_data_ff.netmask == 32'h0) begin
         incl = (cm != 32'h0) && (((rd_data_ff.prefix ^ addr_ff) & cm) == 32'h0)
                && ((cm & lo_ff) == 32'h0);
      end else begin
         incl = (((rd_data_ff.prefix ^ addr_ff) & rd_data_ff.netmask) == 32'h0)
                && ((rd_data_ff.netmask & lo_ff) == 32'h0);
      end
      case (cmd_ff)
         npt_pkg::CMD_ADD:   hit = (rd_data_ff.prefix == addr_ff)
                                   && (rd_data_ff.netmask == mask_ff);
         npt_pkg::CMD_FIND:  hit = (32'(rd_data_ff.ident) == 32'(lid_ff));
         npt_pkg::CMD_MATCH: hit = incl;
         default:            hit = 1'b0;
      endcase
      skip = (cmd_ff == npt_pkg::CMD_NONE)
             || ((cmd_ff == npt_pkg::CMD_MATCH) && (addr_ff == 32'h0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npt_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      lid_in        = lid_ff;
      lo_in         = lo_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      first_id_in   = first_id_ff;
      next_id_in    = next_id_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_addr_in   = res_addr_ff;
      res_mask_in   = res_mask_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[npt_pkg::IDX_BITS-1:0];
      mem_wdata     = '{prefix: addr_ff, netmask: mask_ff, ident: next_id_ff};
      rd_addr       = issue_ff[npt_pkg::IDX_BITS-1:0];
      req_tready    = 1'b0;
      done          = 1'b0;
      found         = 1'b0;

      case (state_ff)
         npt_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = req_tdata[1:0];
               addr_in  = req_tdata[33:2];
               mask_in  = req_tdata[65:34];
               lid_in   = req_tdata[81:66];
               lo_in    = ~req_tdata[65:34] & (req_tdata[65:34] - 32'd1);
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = npt_pkg::FSM_SCAN;
            end
         end
         npt_pkg::FSM_SCAN: begin
            pend_in = 1'b0;
            if (!skip && (issue_ff < count_ff)) begin
               pend_in  = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
            if (skip) begin
               done = 1'b1;
            end else if (pend_ff && hit) begin
               done  = 1'b1;
               found = 1'b1;
            end else if (!pend_ff && (issue_ff >= count_ff)) begin
               done = 1'b1;
            end
            if (done) begin
               state_in = npt_pkg::FSM_OUT;
               if (found) begin
                  res_id_in   = 16'(rd_data_ff.ident);
                  res_addr_in = rd_data_ff.prefix;
                  res_mask_in = rd_data_ff.netmask;
                  case (cmd_ff)
                     npt_pkg::CMD_ADD:  res_status_in = npt_pkg::ST_PRESENT;
                     npt_pkg::CMD_FIND: res_status_in = npt_pkg::ST_FOUND;
                     default:           res_status_in = npt_pkg::ST_MATCHED;
                  endcase
               end else begin
                  res_id_in   = 16'h0;
                  res_addr_in = 32'h0;
                  res_mask_in = 32'h0;
                  case (cmd_ff)
                     npt_pkg::CMD_ADD: begin
                        if (count_ff >= npt_pkg::CNT_BITS'(npt_pkg::TABLE_ENTRIES)) begin
                           res_status_in = npt_pkg::ST_FULL;
                        end else begin
                           res_status_in = npt_pkg::ST_ADDED;
                           res_id_in     = 16'(next_id_ff);
                           res_addr_in   = addr_ff;
                           res_mask_in   = mask_ff;
                           mem_we        = 1'b1;
                           count_in      = count_ff + 1'b1;
                           next_id_in    = next_id_ff + 1'b1;
                        end
                     end
                     npt_pkg::CMD_FIND: res_status_in = npt_pkg::ST_NOT_FOUND;
                     default:           res_status_in = npt_pkg::ST_NO_MATCH;
                  endcase
               end
            end
         end
         npt_pkg::FSM_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = npt_pkg::RSP_BITS'({res_mask_ff, res_addr_ff,
                                                  res_id_ff, res_status_ff});
               state_in     = npt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = npt_pkg::FSM_IDLE;
         end
      endcase

      if (csr_we) begin
         first_id_in = csr_wdata;
         if (count_ff == '0) begin
            next_id_in = npt_pkg::ID_BITS'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         first_id_ff  <= 16'd1;
         next_id_ff   <= npt_pkg::ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         first_id_ff  <= first_id_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      lid_ff        <= lid_in;
      lo_ff         <= lo_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_addr_ff   <= res_addr_in;
      res_mask_ff   <= res_mask_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // entry RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
